// File: design/segx_pkg.sv
// Shared constants for the segment intersection core.
package segx_pkg;

    // Register stages ahead of the divider: differences, products, cross terms, sign fold.
    localparam int unsigned SEGX_FRONT_STAGES = 4;

    // Number of output registers behind the divider.
    localparam int unsigned SEGX_BACK_STAGES = 1;

    function automatic int unsigned segx_latency(input int unsigned coord_bits);
        return SEGX_FRONT_STAGES + coord_bits + SEGX_BACK_STAGES;
    endfunction

endpackage

// File: design/segx_if.sv
// Valid/ready channel interfaces for segment pairs and intersection results.
interface segx_in_if #(
    parameter int unsigned COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface segx_out_if #(
    parameter int unsigned COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

// File: design/segment_intersection_core.sv
// Segment intersection core: cross-product test and pipelined point division.
// Stages: differences, products, cross terms, sign fold, divider, output register.
// Throughput: one beat per cycle when not stalled; the divider retires one
// quotient digit per stage, COORD_BITS stages in all, both coordinates in parallel.
// A stall on the result side holds every stage; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all stage valid bits; no clearing pass.
module segment_intersection_core
    import segx_pkg::*;
#(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    segx_in_if.sink    i_seg,
    segx_out_if.source o_res
);
    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned D  = C + 1;        // difference width
    localparam int unsigned P  = 2 * D;        // product width
    localparam int unsigned W  = P + 1;        // cross term width
    localparam int unsigned R  = W + 2;        // partial remainder width
    localparam int unsigned QB = C + 1;        // quotient width
    localparam int unsigned N  = C;            // divider stages

    logic en;
    assign en          = !o_res.valid || o_res.ready;
    assign i_seg.ready = en;

    // Differences
    logic                r_v1;
    logic signed [D-1:0] r_s1x, r_s1y, r_s2x, r_s2y, r_dx, r_dy;
    logic signed [C-1:0] r_a0x1, r_a0y1;

    // Products
    logic                r_v2;
    logic signed [P-1:0] r_p_den0, r_p_den1, r_p_sn0, r_p_sn1, r_p_tn0, r_p_tn1;
    logic signed [D-1:0] r_s1x2, r_s1y2;
    logic signed [C-1:0] r_a0x2, r_a0y2;

    // Cross terms
    logic                r_v3;
    logic signed [W-1:0] r_den, r_sn, r_tn;
    logic signed [D-1:0] r_s1x3, r_s1y3;
    logic signed [C-1:0] r_a0x3, r_a0y3;

    // Divider stages, index 0 is the sign fold
    logic                r_dv   [0:N];
    logic                r_hit  [0:N];
    logic [W-1:0]        r_dn   [0:N];
    logic [W-1:0]        r_tnn  [0:N];
    logic [C-1:0]        r_magx [0:N];
    logic [C-1:0]        r_magy [0:N];
    logic                r_negx [0:N];
    logic                r_negy [0:N];
    logic signed [C-1:0] r_a0x  [0:N];
    logic signed [C-1:0] r_a0y  [0:N];
    logic [W-1:0]        r_remx [0:N];
    logic [W-1:0]        r_remy [0:N];
    logic [QB-1:0]       r_qx   [0:N];
    logic [QB-1:0]       r_qy   [0:N];

    logic [W-1:0]  n_remx [0:N-1];
    logic [W-1:0]  n_remy [0:N-1];
    logic [QB-1:0] n_qx   [0:N-1];
    logic [QB-1:0] n_qy   [0:N-1];

    function automatic logic [W+QB-1:0] segx_digit(
        input logic [W-1:0]  rem,
        input logic [QB-1:0] q,
        input logic          bit_in,
        input logic [W-1:0]  tn,
        input logic [W-1:0]  den
    );
        logic [R-1:0]  r2;
        logic [R-1:0]  d1;
        logic [R-1:0]  d2;
        logic [R-1:0]  rn;
        logic [QB-1:0] qn;
        r2 = {1'b0, rem, 1'b0} + (bit_in ? {2'b00, tn} : '0);
        d1 = {2'b00, den};
        d2 = {1'b0, den, 1'b0};
        qn = {q[QB-2:0], 1'b0};
        if (r2 >= d2) begin
            rn = r2 - d2;
            qn = qn + QB'(2);
        end else if (r2 >= d1) begin
            rn = r2 - d1;
            qn = qn + QB'(1);
        end else begin
            rn = r2;
        end
        return {rn[W-1:0], qn};
    endfunction

    logic signed [W-1:0] n_den, n_sn, n_tn;
    logic                n_neg;

    always_comb begin
        n_neg = r_den[W-1];
        n_den = n_neg ? -r_den : r_den;
        n_sn  = n_neg ? -r_sn  : r_sn;
        n_tn  = n_neg ? -r_tn  : r_tn;
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            {n_remx[k], n_qx[k]} = segx_digit(r_remx[k], r_qx[k], r_magx[k][N-1-k],
                                               r_tnn[k], r_dn[k]);
            {n_remy[k], n_qy[k]} = segx_digit(r_remy[k], r_qy[k], r_magy[k][N-1-k],
                                               r_tnn[k], r_dn[k]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int k = 0; k <= N; k++) r_dv[k] <= 1'b0;
            o_res.valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_seg.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_dv[0] <= r_v3;
            for (int k = 0; k < N; k++) r_dv[k+1] <= r_dv[k];
            o_res.valid <= r_dv[N];
        end
    end

    logic signed [QB-1:0] n_offx, n_offy;
    logic signed [C-1:0]  n_cx, n_cy;

    always_comb begin
        n_offx = r_negx[N] ? -$signed(r_qx[N]) : $signed(r_qx[N]);
        n_offy = r_negy[N] ? -$signed(r_qy[N]) : $signed(r_qy[N]);
        n_cx   = r_hit[N] ? C'(r_a0x[N] + n_offx[C-1:0]) : '0;
        n_cy   = r_hit[N] ? C'(r_a0y[N] + n_offy[C-1:0]) : '0;
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1x  <= D'(i_seg.first_end_x) - D'(i_seg.first_start_x);
            r_s1y  <= D'(i_seg.first_end_y) - D'(i_seg.first_start_y);
            r_s2x  <= D'(i_seg.second_end_x) - D'(i_seg.second_start_x);
            r_s2y  <= D'(i_seg.second_end_y) - D'(i_seg.second_start_y);
            r_dx   <= D'(i_seg.first_start_x) - D'(i_seg.second_start_x);
            r_dy   <= D'(i_seg.first_start_y) - D'(i_seg.second_start_y);
            r_a0x1 <= i_seg.first_start_x;
            r_a0y1 <= i_seg.first_start_y;

            r_p_den0 <= P'(r_s1x) * P'(r_s2y);
            r_p_den1 <= P'(r_s2x) * P'(r_s1y);
            r_p_sn0  <= P'(r_s1x) * P'(r_dy);
            r_p_sn1  <= P'(r_s1y) * P'(r_dx);
            r_p_tn0  <= P'(r_s2x) * P'(r_dy);
            r_p_tn1  <= P'(r_s2y) * P'(r_dx);
            r_s1x2   <= r_s1x;
            r_s1y2   <= r_s1y;
            r_a0x2   <= r_a0x1;
            r_a0y2   <= r_a0y1;

            r_den  <= W'(r_p_den0) - W'(r_p_den1);
            r_sn   <= W'(r_p_sn0) - W'(r_p_sn1);
            r_tn   <= W'(r_p_tn0) - W'(r_p_tn1);
            r_s1x3 <= r_s1x2;
            r_s1y3 <= r_s1y2;
            r_a0x3 <= r_a0x2;
            r_a0y3 <= r_a0y2;

            r_hit[0]  <= (r_den != '0) && !n_sn[W-1] && !n_tn[W-1]
                         && (n_sn <= n_den) && (n_tn <= n_den);
            r_dn[0]   <= n_den;
            r_tnn[0]  <= n_tn;
            r_negx[0] <= r_s1x3[D-1];
            r_negy[0] <= r_s1y3[D-1];
            r_magx[0] <= r_s1x3[D-1] ? C'(-r_s1x3) : C'(r_s1x3);
            r_magy[0] <= r_s1y3[D-1] ? C'(-r_s1y3) : C'(r_s1y3);
            r_a0x[0]  <= r_a0x3;
            r_a0y[0]  <= r_a0y3;
            r_remx[0] <= '0;
            r_remy[0] <= '0;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;

            for (int k = 0; k < N; k++) begin
                r_hit[k+1]  <= r_hit[k];
                r_dn[k+1]   <= r_dn[k];
                r_tnn[k+1]  <= r_tnn[k];
                r_negx[k+1] <= r_negx[k];
                r_negy[k+1] <= r_negy[k];
                r_magx[k+1] <= r_magx[k];
                r_magy[k+1] <= r_magy[k];
                r_a0x[k+1]  <= r_a0x[k];
                r_a0y[k+1]  <= r_a0y[k];
                r_remx[k+1] <= n_remx[k];
                r_remy[k+1] <= n_remy[k];
                r_qx[k+1]   <= n_qx[k];
                r_qy[k+1]   <= n_qy[k];
            end

            o_res.hit     <= r_hit[N];
            o_res.cross_x <= n_cx;
            o_res.cross_y <= n_cy;
        end
    end

endmodule

// File: design/segx_checker.sv
// Port-level checker for the segment intersection core, with its bind.
module segx_checker
    import segx_pkg::*;
#(
    parameter int unsigned COORD_BITS = 24
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_hit,
    input logic signed [COORD_BITS-1:0] i_cross_x,
    input logic signed [COORD_BITS-1:0] i_cross_y
);
    localparam int unsigned LAT = segx_latency(COORD_BITS);

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output space");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_cross_x == '0 && i_cross_y == '0)
        else $error("miss carries a nonzero point");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit)
            && $stable(i_cross_x) && $stable(i_cross_y))
        else $error("stalled result beat changed");

    a_fill_time: assert property (@(posedge i_clk)
        $past(!i_rst_n, 1) && i_rst_n && LAT > 1 |-> !i_out_valid)
        else $error("result beat before pipeline fill");

endmodule

bind segment_intersection_core segx_checker #(.COORD_BITS(COORD_BITS)) u_segx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.hit),
    .i_cross_x   (o_res.cross_x),
    .i_cross_y   (o_res.cross_y)
);

// File: test/segment_intersection_core_check.sv
// Checker for the segment intersection core: predicts each result and compares beats.
`timescale 1ns / 1ps
module segment_intersection_core_check #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    segx_in_if         i_seg,
    segx_out_if        o_res,
    output int         o_fail_count,
    output int         o_pending
);
    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } crossing_t;

    crossing_t crossing_q[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = crossing_q.size();

    function automatic logic signed [COORD_BITS-1:0] point_on(
        input logic signed [127:0] start, input logic signed [127:0] dir,
        input logic signed [127:0] tnum, input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] quo;
        begin
            mag = dir < 0 ? -dir : dir;
            quo = (tnum * mag) / den;
            if (dir < 0) quo = -quo;
            return COORD_BITS'(start + quo);
        end
    endfunction

    function automatic crossing_t predict_crossing(
        input logic signed [COORD_BITS-1:0] ax0, input logic signed [COORD_BITS-1:0] ay0,
        input logic signed [COORD_BITS-1:0] ax1, input logic signed [COORD_BITS-1:0] ay1,
        input logic signed [COORD_BITS-1:0] bx0, input logic signed [COORD_BITS-1:0] by0,
        input logic signed [COORD_BITS-1:0] bx1, input logic signed [COORD_BITS-1:0] by1);
        logic signed [127:0] s1x, s1y, s2x, s2y, dx, dy, den, snum, tnum;
        crossing_t r;
        begin
            r    = '0;
            s1x  = 128'(ax1) - 128'(ax0);
            s1y  = 128'(ay1) - 128'(ay0);
            s2x  = 128'(bx1) - 128'(bx0);
            s2y  = 128'(by1) - 128'(by0);
            dx   = 128'(ax0) - 128'(bx0);
            dy   = 128'(ay0) - 128'(by0);
            den  = s1x * s2y - s2x * s1y;
            snum = s1x * dy - s1y * dx;
            tnum = s2x * dy - s2y * dx;
            if (den != 0) begin
                if (den < 0) begin
                    den  = -den;
                    snum = -snum;
                    tnum = -tnum;
                end
                if (snum >= 0 && tnum >= 0 && snum <= den && tnum <= den) begin
                    r.hit     = 1'b1;
                    r.cross_x = point_on(128'(ax0), s1x, tnum, den);
                    r.cross_y = point_on(128'(ay0), s1y, tnum, den);
                end
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input crossing_t got,
                                   input crossing_t want);
        begin
            fail_count++;
            $display("mismatch %s: got hit=%0d x=%0d y=%0d, want hit=%0d x=%0d y=%0d",
                     what, got.hit, got.cross_x, got.cross_y,
                     want.hit, want.cross_x, want.cross_y);
        end
    endtask

    always @(posedge i_clk) begin
        crossing_t got;
        crossing_t want;
        if (i_rst_n) begin
            if (i_seg.valid && i_seg.ready)
                crossing_q.insert(crossing_q.size(), predict_crossing(
                    i_seg.first_start_x, i_seg.first_start_y,
                    i_seg.first_end_x, i_seg.first_end_y,
                    i_seg.second_start_x, i_seg.second_start_y,
                    i_seg.second_end_x, i_seg.second_end_y));
            if (o_res.valid && o_res.ready) begin
                got = '{o_res.hit, o_res.cross_x, o_res.cross_y};
                if (crossing_q.size() == 0) begin
                    report_mismatch("unexpected beat", got, '0);
                end else begin
                    want = crossing_q.pop_front();
                    if (got.hit !== want.hit) report_mismatch("hit", got, want);
                    if (got.cross_x !== want.cross_x) report_mismatch("cross_x", got, want);
                    if (got.cross_y !== want.cross_y) report_mismatch("cross_y", got, want);
                end
            end
        end
    end
endmodule

// File: test/segment_intersection_core_tb.sv
// Testbench top: drives segment pairs through the core and gives the verdict.
`timescale 1ns / 1ps
module segment_intersection_core_tb;
    import segx_pkg::*;

    localparam int unsigned CB      = 24;
    localparam int          LATENCY = segx_latency(CB);
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    segx_in_if  #(.COORD_BITS(CB)) seg_ch ();
    segx_out_if #(.COORD_BITS(CB)) res_ch ();

    segment_intersection_core #(.COORD_BITS(CB)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_ch.sink),
        .o_res  (res_ch.source)
    );

    segment_intersection_core_check #(.COORD_BITS(CB)) i_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (seg_ch),
        .o_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic signed [CB-1:0] rand_coord(input int span);
        begin
            case ($urandom_range(3))
                0: return CB'($urandom);
                1: return CB'($signed($urandom_range(2 * span)) - span);
                2: return $urandom_range(1) ? CMAX : CMIN;
                default: return CB'($signed($urandom_range(2 * span)) - span) <<< 8;
            endcase
        end
    endfunction

    task automatic send_pair(input logic signed [CB-1:0] c[8]);
        begin
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
            seg_ch.valid          = 1'b1;
            seg_ch.first_start_x  = c[0];
            seg_ch.first_start_y  = c[1];
            seg_ch.first_end_x    = c[2];
            seg_ch.first_end_y    = c[3];
            seg_ch.second_start_x = c[4];
            seg_ch.second_start_y = c[5];
            seg_ch.second_end_x   = c[6];
            seg_ch.second_end_y   = c[7];
            do @(posedge i_clk); while (!seg_ch.ready);
            @(negedge i_clk);
            seg_ch.valid = 1'b0;
        end
    endtask

    task automatic send_crossing(input int span);
        logic signed [CB-1:0] c[8];
        int                   cx, cy;
        begin
            // build segments straddling a common point, mostly a hit
            cx   = $signed($urandom_range(2 * span)) - span;
            cy   = $signed($urandom_range(2 * span)) - span;
            c[0] = CB'(cx - $signed($urandom_range(span)));
            c[1] = CB'(cy - $signed($urandom_range(span)));
            c[2] = CB'(cx + $signed($urandom_range(span)));
            c[3] = CB'(cy + $signed($urandom_range(span)));
            c[4] = CB'(cx - $signed($urandom_range(span)));
            c[5] = CB'(cy + $signed($urandom_range(span)));
            c[6] = CB'(cx + $signed($urandom_range(span)));
            c[7] = CB'(cy - $signed($urandom_range(span)));
            send_pair(c);
        end
    endtask

    initial begin
        logic signed [CB-1:0] c[8];
        int                   guard;
        seg_ch.valid = 1'b0;
        seg_ch.first_start_x  = '0;
        seg_ch.first_start_y  = '0;
        seg_ch.first_end_x    = '0;
        seg_ch.first_end_y    = '0;
        seg_ch.second_start_x = '0;
        seg_ch.second_start_y = '0;
        seg_ch.second_end_x   = '0;
        seg_ch.second_end_y   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // plain crossing
        c = '{-256, 0, 256, 0, 0, -256, 0, 256};
        send_pair(c);
        // parallel and degenerate
        c = '{0, 0, 256, 0, 0, 256, 256, 256};
        send_pair(c);
        c = '{5, 5, 5, 5, 9, 9, 9, 9};
        send_pair(c);
        // collinear overlap
        c = '{0, 0, 512, 0, 256, 0, 768, 0};
        send_pair(c);
        // touching at endpoints
        c = '{0, 0, 256, 256, 256, 256, 512, 0};
        send_pair(c);
        c = '{0, 0, 256, 0, 256, -256, 256, 256};
        send_pair(c);
        // lines cross outside the segments
        c = '{0, 0, 256, 0, 512, -256, 512, 256};
        send_pair(c);
        // full-scale diagonals and axes, both orientations
        c = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN};
        send_pair(c);
        c = '{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX};
        send_pair(c);
        c = '{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX};
        send_pair(c);
        c = '{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX};
        send_pair(c);
        // truncation toward zero with negative direction
        c = '{7, 3, -5, -4, -9, 1, 6, -2};
        send_pair(c);
        c = '{-1, -1, 2, 1, 0, 2, 1, -3};
        send_pair(c);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            for (int n = 0; n < 185; n++) begin
                if ($urandom_range(99) < 65) begin
                    send_crossing($urandom_range(1) ? 1000 : 4_000_000);
                end else begin
                    for (int k = 0; k < 8; k++) c[k] = rand_coord(3000);
                    send_pair(c);
                end
            end
        end

        guard = 0;
        while (pending != 0 && guard < 100_000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: segment_intersection_core.f
design/segx_pkg.sv
design/segx_if.sv
design/segment_intersection_core.sv
design/segx_checker.sv
test/segment_intersection_core_check.sv
test/segment_intersection_core_tb.sv
